FILE: rtl/core/gas_sensor_frame_decoder_top_defines.svh
// Assertion macros for the gas sensor frame decoder.
// Included by gas_sensor_frame_decoder_top.sv; no other dependencies.
// Empty bodies when SYNTHESIS is defined.
`ifndef GAS_SENSOR_FRAME_DECODER_TOP_DEFINES_SVH
`define GAS_SENSOR_FRAME_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GSFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gsfd assertion failed");
`define GSFD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("gsfd assertion failed");
`else
`define GSFD_ASSERT(label, clk, rst_n, prop)
`define GSFD_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: rtl/core/gsfd_pkg.sv
// Shared types and constants for the gas sensor frame decoder.
// No dependencies; used by gsfd_parser and the top level.
package gsfd_pkg;

    localparam int          FRAME_LENGTH_DEFAULT = 9;
    localparam logic [7:0]  START_BYTE           = 8'hFF;
    localparam logic [7:0]  COMMAND_RESET        = 8'h86;

    localparam logic [1:0]  STATUS_OK            = 2'd0;
    localparam logic [1:0]  STATUS_BAD_COMMAND   = 2'd1;
    localparam logic [1:0]  STATUS_BAD_CHECKSUM  = 2'd2;

    // Result of the byte currently being accepted
    typedef struct packed {
        logic        done;
        logic [15:0] concentration;
        logic [1:0]  status;
    } frame_result_t;

    // Parser state seen by the top level
    typedef struct packed {
        logic in_frame;
        logic at_last;
    } parser_state_t;

endpackage

FILE: rtl/core/gsfd_parser.sv
// Frame hunter and checker: position counter, running sum, captured fields.
// Depends on gsfd_pkg.
module gsfd_parser #(
    parameter int FRAME_LENGTH = gsfd_pkg::FRAME_LENGTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     byte_accept,
    input  logic [7:0]               rx_byte,
    input  logic [7:0]               expected_command,
    output gsfd_pkg::frame_result_t  result,
    output gsfd_pkg::parser_state_t  pstate
);

    localparam int POS_W = $clog2(FRAME_LENGTH);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);
    localparam logic [POS_W-1:0] POS_CMD  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_HIGH = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LOW  = POS_W'(3);

    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic             cmd_ok_reg, cmd_ok_next;
    logic [7:0]       val_high_reg, val_high_next;
    logic [7:0]       val_low_reg, val_low_next;
    logic             at_last;
    logic [7:0]       want;

    assign at_last = in_frame_reg && (pos_reg == LAST_POS);
    assign want    = 8'(8'd0 - sum_reg);

    always_comb
    begin
        result.done          = byte_accept && at_last;
        result.concentration = {val_high_reg, val_low_reg};
        if (!cmd_ok_reg)
            result.status = gsfd_pkg::STATUS_BAD_COMMAND;
        else if (rx_byte != want)
            result.status = gsfd_pkg::STATUS_BAD_CHECKSUM;
        else
            result.status = gsfd_pkg::STATUS_OK;
    end

    assign pstate.in_frame = in_frame_reg;
    assign pstate.at_last  = at_last;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        cmd_ok_next   = cmd_ok_reg;
        val_high_next = val_high_reg;
        val_low_next  = val_low_reg;
        if (byte_accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == gsfd_pkg::START_BYTE)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = POS_CMD;
                    sum_next      = 8'd0;
                    cmd_ok_next   = 1'b0;
                    val_high_next = 8'd0;
                    val_low_next  = 8'd0;
                end
            end
            else if (at_last)
            begin
                in_frame_next = 1'b0;
                pos_next      = '0;
            end
            else
            begin
                if (pos_reg == POS_CMD)
                    cmd_ok_next = (rx_byte == expected_command);
                if (pos_reg == POS_HIGH)
                    val_high_next = rx_byte;
                if (pos_reg == POS_LOW)
                    val_low_next = rx_byte;
                sum_next = 8'(sum_reg + rx_byte);
                pos_next = POS_W'(pos_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            sum_reg      <= 8'd0;
            cmd_ok_reg   <= 1'b0;
            val_high_reg <= 8'd0;
            val_low_reg  <= 8'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            cmd_ok_reg   <= cmd_ok_next;
            val_high_reg <= val_high_next;
            val_low_reg  <= val_low_next;
        end
    end

endmodule

FILE: rtl/core/gas_sensor_frame_decoder_top.sv
// Gas sensor frame decoder, top level: command register, parser, result register.
// Depends on gsfd_pkg, gsfd_parser and gas_sensor_frame_decoder_top_defines.svh.
//
// Takes one received serial byte per beat and hunts for the 0xFF start byte.
// A start byte opens a frame of FRAME_LENGTH bytes; byte 1 is compared with
// the command register (reset 0x86), bytes 1 to FRAME_LENGTH-2 are summed
// mod 256, and bytes 2 and 3 give the 16-bit concentration, high byte first.
// On the last byte one result beat carries the concentration and a status:
// 0 ok, 1 wrong command (wins over a checksum error), 2 last byte is not the
// two's complement of the sum. Error results still carry bytes 2 and 3. A
// 0xFF inside a frame is plain data. The parser state and, on the last
// byte, the output register both load at the edge that takes the beat, so
// the result beat is offered from the next cycle and a byte can be taken
// every cycle while in_ready is high. in_ready drops only when the parser
// is at the last frame byte and the output register still holds an
// untaken result. The command register is written with cfg_we/cfg_wdata;
// the user must write it only while the block is idle, and the block itself
// does not enforce this. The compare uses the value present when byte 1 arrives.
`include "gas_sensor_frame_decoder_top_defines.svh"

module gas_sensor_frame_decoder_top #(
    parameter int FRAME_LENGTH = gsfd_pkg::FRAME_LENGTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] concentration,
    output logic [1:0]  status,
    // command register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    logic                    in_beat;
    logic [7:0]              command_reg;
    gsfd_pkg::frame_result_t result;
    gsfd_pkg::parser_state_t pstate;

    logic                    out_valid_reg, out_valid_next;
    logic [15:0]             conc_reg;
    logic [1:0]              status_reg;

    // Stall only a byte that would produce a result into a full output slot.
    assign in_ready = !(pstate.at_last && out_valid_reg && !out_ready);
    assign in_beat  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            command_reg <= gsfd_pkg::COMMAND_RESET;
        else if (cfg_we)
            command_reg <= cfg_wdata;
    end

    gsfd_parser #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_accept      (in_beat),
        .rx_byte          (rx_byte),
        .expected_command (command_reg),
        .result           (result),
        .pstate           (pstate)
    );

    // Output register: loads on a finished frame, drains on out_ready.
    always_comb
    begin
        if (result.done)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result.done)
        begin
            conc_reg   <= result.concentration;
            status_reg <= result.status;
        end
    end

    assign out_valid     = out_valid_reg;
    assign concentration = conc_reg;
    assign status        = status_reg;

    // A finished frame always shows up as a result beat next cycle.
    `GSFD_ASSERT(a_done_sets_valid, clk, rst_n, result.done |=> out_valid_reg)
    // Never overwrite a result that has not been taken.
    `GSFD_ASSERT(a_no_overwrite, clk, rst_n,
        (out_valid_reg && !out_ready) |-> !result.done)
    // After the last byte the parser is back to hunting.
    `GSFD_ASSERT(a_hunt_after_done, clk, rst_n, result.done |=> !pstate.in_frame)
    // Only the three defined status codes leave the block.
    `GSFD_ASSERT(a_status_legal, clk, rst_n,
        out_valid_reg |-> (status_reg == gsfd_pkg::STATUS_OK ||
        status_reg == gsfd_pkg::STATUS_BAD_COMMAND ||
        status_reg == gsfd_pkg::STATUS_BAD_CHECKSUM))
    // The last-byte flag implies an open frame.
    `GSFD_ASSERT_ALWAYS(a_last_in_frame, clk, pstate.at_last |-> pstate.in_frame)

endmodule
